@@ rtl/brl_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package brl_pkg;

   localparam int COORD_W = 6;
   localparam int COLOR_W = 24;
   localparam int BYTE_W  = 8;
   // error term stays within about plus/minus one and a half major spans
   localparam int ERR_W   = COORD_W + 3;

   typedef logic [COORD_W-1:0]        coord_type;
   typedef logic [COLOR_W-1:0]        color_type;
   typedef logic [BYTE_W-1:0]         byte_type;
   typedef logic signed [ERR_W-1:0]   err_type;

   // controller to datapath
   typedef struct packed {
      logic load;   // capture a new segment and set up the walk
      logic step;   // emit current pixel and advance
   } brl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic at_end; // current pixel is the final one
   } brl_status_type;

endpackage

`default_nettype wire

@@ rtl/brl_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module brl_ctrl (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     start,
   input  brl_pkg::brl_status_type status,
   output brl_pkg::brl_cmd_type    cmd,
   output logic                    busy
);
   import brl_pkg::*;

   typedef enum logic {
      ST_IDLE,
      ST_WALK
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      busy_ff;
   logic      busy_in;

   always_comb begin
      cmd.load = start && !busy_ff;
      cmd.step = (state_ff == ST_WALK);
   end

   always_comb begin
      state_in = state_ff;
      busy_in  = busy_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_WALK;
               busy_in  = 1'b1;
            end
         end
         ST_WALK: begin
            // drop busy after the final pixel goes out
            if (status.at_end) begin
               state_in = ST_IDLE;
               busy_in  = 1'b0;
            end
         end
         default: begin
            state_in = ST_IDLE;
            busy_in  = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         busy_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         busy_ff  <= busy_in;
      end
   end

   assign busy = busy_ff;

endmodule

`default_nettype wire

@@ rtl/brl_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none

module brl_datapath #(
   parameter int TILE_SIZE = 64
) (
   input  wire                     clock,
   input  wire                     reset,
   input  brl_pkg::brl_cmd_type    cmd,
   output brl_pkg::brl_status_type status,
   input  brl_pkg::coord_type      first_x,
   input  brl_pkg::coord_type      first_y,
   input  brl_pkg::coord_type      second_x,
   input  brl_pkg::coord_type      second_y,
   input  wire                     color_we,
   input  brl_pkg::color_type      color_wdata,
   output brl_pkg::coord_type      pixel_x,
   output brl_pkg::coord_type      pixel_y,
   output brl_pkg::byte_type       red,
   output brl_pkg::byte_type       green,
   output brl_pkg::byte_type       blue,
   output logic                    last
);
   import brl_pkg::*;

   localparam int COORD_MAX = (1 << COORD_W) - 1;
   localparam int CLAMP     = (TILE_SIZE - 1 > COORD_MAX) ? COORD_MAX : TILE_SIZE - 1;
   localparam coord_type CLAMP_C = coord_type'(CLAMP);

   coord_type ax, ay, bx, by;
   coord_type dx, dy;
   logic      x_major;
   logic      first_starts;
   coord_type s_maj, e_maj, s_min, e_min;

   coord_type major_ff, minor_ff, end_major_ff, maj_span_ff, min_span_ff;
   coord_type end_minor_w;
   logic      x_major_ff, step_up_ff, step_on_ff;
   err_type   err_ff;
   color_type color_ff;

   err_type               err_sum;
   logic signed [ERR_W:0] err_dbl;
   logic signed [ERR_W:0] maj_ext;
   logic                  minor_move;

   // clamp endpoints into the tile
   always_comb begin
      ax = (first_x  > CLAMP_C) ? CLAMP_C : first_x;
      ay = (first_y  > CLAMP_C) ? CLAMP_C : first_y;
      bx = (second_x > CLAMP_C) ? CLAMP_C : second_x;
      by = (second_y > CLAMP_C) ? CLAMP_C : second_y;
      dx = (ax > bx) ? ax - bx : bx - ax;
      dy = (ay > by) ? ay - by : by - ay;
      x_major = dx > dy;
      if (x_major) begin
         first_starts = ax < bx;
         s_maj = first_starts ? ax : bx;
         s_min = first_starts ? ay : by;
         e_maj = first_starts ? bx : ax;
         e_min = first_starts ? by : ay;
      end else begin
         first_starts = ay < by;
         s_maj = first_starts ? ay : by;
         s_min = first_starts ? ax : bx;
         e_maj = first_starts ? by : ay;
         e_min = first_starts ? bx : ax;
      end
      end_minor_w = e_min;
   end

   // error update for the next pixel
   always_comb begin
      err_sum    = err_ff + err_type'({1'b0, min_span_ff});
      err_dbl    = {err_sum, 1'b0};
      maj_ext    = (ERR_W+1)'({1'b0, maj_span_ff});
      minor_move = (err_dbl >= maj_ext);
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         major_ff     <= s_maj;
         minor_ff     <= s_min;
         end_major_ff <= e_maj;
         maj_span_ff  <= x_major ? dx : dy;
         min_span_ff  <= x_major ? dy : dx;
         x_major_ff   <= x_major;
         step_up_ff   <= end_minor_w > s_min;
         step_on_ff   <= end_minor_w != s_min;
         err_ff       <= '0;
      end else if (cmd.step) begin
         major_ff <= major_ff + coord_type'(1);
         if (minor_move) begin
            err_ff <= err_sum - err_type'({1'b0, maj_span_ff});
            if (step_on_ff) begin
               minor_ff <= step_up_ff ? minor_ff + coord_type'(1)
                                      : minor_ff - coord_type'(1);
            end
         end else begin
            err_ff <= err_sum;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         color_ff <= '0;
      end else if (color_we) begin
         color_ff <= color_wdata;
      end
   end

   assign status.at_end = (major_ff == end_major_ff);

   assign pixel_x = x_major_ff ? major_ff : minor_ff;
   assign pixel_y = x_major_ff ? minor_ff : major_ff;
   assign red     = color_ff[2*BYTE_W +: BYTE_W];
   assign green   = color_ff[BYTE_W +: BYTE_W];
   assign blue    = color_ff[0 +: BYTE_W];
   assign last    = status.at_end;

endmodule

`default_nettype wire

@@ rtl/bresenham_line_rasterizer_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel   Ports                                   Handshake
// -------   -------------------------------------   ------------------------------
// request   req_first_x/y, req_second_x/y           start high while busy low
// response  rsp_pixel_x/y, rsp_red/green/blue,      rsp_valid high with each word, one
//           rsp_last                                word per cycle, no back-pressure
// csr       csr_line_color                          csr_valid with csr_ready
//
// A segment of N pixels keeps busy high from the accept edge until its final
// word has left; one word leaves per cycle, and a new segment is taken only
// once busy is low. The single walk counter and its error accumulator step
// the walk. Reset is synchronous and active high; it clears the controller
// and the color register to zero. The receiver cannot stall the word stream.

module bresenham_line_rasterizer_core #(
   parameter int TILE_SIZE = 64
) (
   input  wire                clock,
   input  wire                reset,
   // request
   input  wire                start,
   output logic               busy,
   input  brl_pkg::coord_type req_first_x,
   input  brl_pkg::coord_type req_first_y,
   input  brl_pkg::coord_type req_second_x,
   input  brl_pkg::coord_type req_second_y,
   // response
   output logic               rsp_valid,
   output brl_pkg::coord_type rsp_pixel_x,
   output brl_pkg::coord_type rsp_pixel_y,
   output brl_pkg::byte_type  rsp_red,
   output brl_pkg::byte_type  rsp_green,
   output brl_pkg::byte_type  rsp_blue,
   output logic               rsp_last,
   // configuration
   input  wire                csr_valid,
   output logic               csr_ready,
   input  brl_pkg::color_type csr_line_color
);
   import brl_pkg::*;

   brl_cmd_type    cmd;
   brl_status_type status;

   // color register takes every write at once
   assign csr_ready = 1'b1;

   brl_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .cmd    (cmd),
      .busy   (busy)
   );

   // the walk emits a word in every cycle it is stepping
   assign rsp_valid = cmd.step;

   brl_datapath #(
      .TILE_SIZE (TILE_SIZE)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .first_x     (req_first_x),
      .first_y     (req_first_y),
      .second_x    (req_second_x),
      .second_y    (req_second_y),
      .color_we    (csr_valid && csr_ready),
      .color_wdata (csr_line_color),
      .pixel_x     (rsp_pixel_x),
      .pixel_y     (rsp_pixel_y),
      .red         (rsp_red),
      .green       (rsp_green),
      .blue        (rsp_blue),
      .last        (rsp_last)
   );

`ifndef NO_ASSERTIONS
   // an accepted segment always starts a walk
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy && rsp_valid))
      else $error("accepted segment did not start a walk");

   // words only leave while a segment is in flight
   a_valid_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("word emitted while idle");

   // the final word releases the block
   a_last_release: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last) |=> !busy)
      else $error("busy held after final word");

   // the walk is unbroken until the final word
   a_walk_cont: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |=> rsp_valid)
      else $error("walk broke off before final word");
`endif

endmodule

`default_nettype wire

@@ sim/bresenham_line_rasterizer_core_tb.sv @@
`timescale 1ns / 1ps

module bresenham_line_rasterizer_core_tb;
   import brl_pkg::*;

   // generous bound on the run: ~230 segments plus gaps and drains
   localparam int CYCLE_LIMIT = 200000;
   // cycles to let pass after the last word before touching the register
   localparam int SETTLE_CYCLES = 4;

   typedef struct packed {
      coord_type px;
      coord_type py;
      byte_type  red;
      byte_type  green;
      byte_type  blue;
      logic      last;
   } pixel_word_type;

   logic      clock;
   logic      reset;
   logic      start;
   logic      busy;
   coord_type req_first_x;
   coord_type req_first_y;
   coord_type req_second_x;
   coord_type req_second_y;
   logic      rsp_valid;
   coord_type rsp_pixel_x;
   coord_type rsp_pixel_y;
   byte_type  rsp_red;
   byte_type  rsp_green;
   byte_type  rsp_blue;
   logic      rsp_last;
   logic      csr_valid;
   logic      csr_ready;
   color_type csr_line_color;

   // pixels still owed by the block, oldest first
   pixel_word_type pending_pixels[$];
   pixel_word_type oldest_pixel;
   // our copy of the color register
   color_type      shadow_color;
   int             mismatches;
   int             cycle_count;
   bit             gaps_on;

   bresenham_line_rasterizer_core #(
      .TILE_SIZE(64)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_first_x    (req_first_x),
      .req_first_y    (req_first_y),
      .req_second_x   (req_second_x),
      .req_second_y   (req_second_y),
      .rsp_valid      (rsp_valid),
      .rsp_pixel_x    (rsp_pixel_x),
      .rsp_pixel_y    (rsp_pixel_y),
      .rsp_red        (rsp_red),
      .rsp_green      (rsp_green),
      .rsp_blue       (rsp_blue),
      .rsp_last       (rsp_last),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_line_color (csr_line_color)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Walk the segment the way the block should and queue one word per pixel.
   // The longer axis is the major one; a tie walks along y. The walk starts
   // at the end with the smaller major coordinate, and the minor coordinate
   // steps once twice the error reaches the major span.
   function automatic void trace_segment(coord_type ax, coord_type ay,
                                         coord_type bx, coord_type by);
      int             dx, dy, maj_span, min_span;
      int             s_maj, e_maj, s_min, e_min;
      int             err, dir, minor, major;
      bit             x_major;
      pixel_word_type w;
      dx = (ax > bx) ? ax - bx : bx - ax;
      dy = (ay > by) ? ay - by : by - ay;
      x_major = dx > dy;
      if (x_major) begin
         s_maj = (ax < bx) ? ax : bx;
         s_min = (ax < bx) ? ay : by;
         e_maj = (ax < bx) ? bx : ax;
         e_min = (ax < bx) ? by : ay;
         maj_span = dx;
         min_span = dy;
      end else begin
         s_maj = (ay < by) ? ay : by;
         s_min = (ay < by) ? ax : bx;
         e_maj = (ay < by) ? by : ay;
         e_min = (ay < by) ? bx : ax;
         maj_span = dy;
         min_span = dx;
      end
      dir = (e_min > s_min) ? 1 : ((e_min < s_min) ? -1 : 0);
      minor = s_min;
      err = 0;
      w.red   = shadow_color[23:16];
      w.green = shadow_color[15:8];
      w.blue  = shadow_color[7:0];
      // a 6 bit coordinate never passes the tile, so at most 64 pixels
      for (major = s_maj; major <= e_maj; major++) begin
         w.px   = coord_type'(x_major ? major : minor);
         w.py   = coord_type'(x_major ? minor : major);
         w.last = (major == e_maj);
         pending_pixels.push_back(w);
         err += min_span;
         if (2 * err >= maj_span) begin
            minor += dir;
            err -= maj_span;
         end
      end
   endfunction

   // Hold start low for a random burst, at random, when idling is on.
   task automatic hold_off();
      if (gaps_on && $urandom_range(0, 2) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
   endtask

   // Present one segment and wait for the accept edge. Start stays high on
   // return so that a back-to-back caller can reassign it in the same step.
   task automatic send_segment(coord_type ax, coord_type ay,
                               coord_type bx, coord_type by);
      hold_off();
      start        <= 1'b1;
      req_first_x  <= ax;
      req_first_y  <= ay;
      req_second_x <= bx;
      req_second_y <= by;
      do @(posedge clock); while (busy);
      trace_segment(ax, ay, bx, by);
   endtask

   // Drop start and wait until every owed word has come out.
   task automatic drain();
      start <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write the color register once the block is idle.
   task automatic write_line_color(color_type value);
      drain();
      if (gaps_on) repeat ($urandom_range(0, 7)) @(posedge clock);
      csr_valid      <= 1'b1;
      csr_line_color <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid      <= 1'b0;
      shadow_color    = value;
   endtask

   // Pick a segment: mostly anywhere in the tile, some short, some on an axis
   // or a diagonal so that ties and single-span walks come up often.
   task automatic send_random_segment();
      coord_type ax, ay, bx, by;
      int        kind, d;
      ax = coord_type'($urandom_range(0, 63));
      ay = coord_type'($urandom_range(0, 63));
      bx = coord_type'($urandom_range(0, 63));
      by = coord_type'($urandom_range(0, 63));
      kind = $urandom_range(0, 9);
      if (kind >= 6 && kind <= 7) begin
         bx = coord_type'(ax + $urandom_range(0, 6) - 3);
         by = coord_type'(ay + $urandom_range(0, 6) - 3);
      end else if (kind == 8) begin
         if ($urandom_range(0, 1)) bx = ax;
         else by = ay;
      end else if (kind == 9) begin
         d = $urandom_range(0, 63);
         bx = coord_type'((ax + d > 63) ? ax - d : ax + d);
         by = coord_type'((ay + d > 63) ? ay - d : ay + d);
         if (ax + d > 63 && ax < d) bx = ax;
         if (ay + d > 63 && ay < d) by = ay;
      end
      send_segment(ax, ay, bx, by);
   endtask

   task automatic report_field(string name, int expected, int actual);
      if (expected != actual) begin
         $display("%0t: %s mismatch, expected %0h actual %0h",
                  $time, name, expected, actual);
         mismatches++;
      end
   endtask

   // Check every word against the oldest owed pixel.
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pending_pixels.size() == 0) begin
            $display("%0t: unexpected word, expected none actual x=%0d y=%0d",
                     $time, rsp_pixel_x, rsp_pixel_y);
            mismatches++;
         end else begin
            oldest_pixel = pending_pixels.pop_front();
            report_field("pixel_x", oldest_pixel.px, rsp_pixel_x);
            report_field("pixel_y", oldest_pixel.py, rsp_pixel_y);
            report_field("red", oldest_pixel.red, rsp_red);
            report_field("green", oldest_pixel.green, rsp_green);
            report_field("blue", oldest_pixel.blue, rsp_blue);
            report_field("last", oldest_pixel.last, rsp_last);
         end
      end
   end

   // Bound the run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Color out of reset must be black.
   task automatic test_reset_color();
      send_segment(6'd3, 6'd4, 6'd9, 6'd6);
      send_segment(6'd0, 6'd0, 6'd0, 6'd0);
   endtask

   // Extremes, every octant, ties and single-pixel segments.
   task automatic test_directed_segments();
      write_line_color(24'hFFFFFF);
      send_segment(6'd0,  6'd0,  6'd0,  6'd0);
      send_segment(6'd63, 6'd63, 6'd63, 6'd63);
      send_segment(6'd0,  6'd0,  6'd63, 6'd0);
      send_segment(6'd63, 6'd5,  6'd0,  6'd5);
      send_segment(6'd7,  6'd0,  6'd7,  6'd63);
      send_segment(6'd7,  6'd63, 6'd7,  6'd0);
      write_line_color(24'hA55AC3);
      send_segment(6'd0,  6'd0,  6'd63, 6'd63);
      send_segment(6'd63, 6'd0,  6'd0,  6'd63);
      send_segment(6'd0,  6'd0,  6'd63, 6'd1);
      send_segment(6'd63, 6'd62, 6'd0,  6'd63);
      send_segment(6'd0,  6'd0,  6'd1,  6'd63);
      send_segment(6'd10, 6'd40, 6'd50, 6'd20);
      write_line_color(24'h5AA53C);
      send_segment(6'd20, 6'd50, 6'd30, 6'd10);
      send_segment(6'd1,  6'd0,  6'd0,  6'd0);
      send_segment(6'd0,  6'd1,  6'd0,  6'd0);
      send_segment(6'd1,  6'd1,  6'd0,  6'd0);
      send_segment(6'd0,  6'd63, 6'd63, 6'd0);
      send_segment(6'd42, 6'd21, 6'd21, 6'd42);
      send_segment(6'd62, 6'd1,  6'd60, 6'd2);
   endtask

   // Random segments in phases, with a fresh color between phases.
   task automatic test_random_segments();
      color_type palette[4];
      palette[0] = 24'h000000;
      palette[1] = color_type'($urandom);
      palette[2] = 24'hFFFFFF;
      palette[3] = color_type'($urandom);
      foreach (palette[p]) begin
         write_line_color(palette[p]);
         repeat (42) send_random_segment();
      end
   endtask

   // Finish with no gaps so segments follow each other on the accept edge.
   task automatic test_back_to_back();
      gaps_on = 1'b0;
      write_line_color(color_type'($urandom));
      repeat (30) send_random_segment();
   endtask

   initial begin
      int waited;
      mismatches   = 0;
      cycle_count  = 0;
      gaps_on      = 1'b1;
      shadow_color = '0;
      reset          <= 1'b1;
      start          <= 1'b0;
      req_first_x    <= '0;
      req_first_y    <= '0;
      req_second_x   <= '0;
      req_second_y   <= '0;
      csr_valid      <= 1'b0;
      csr_line_color <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_color();
      test_directed_segments();
      test_random_segments();
      test_back_to_back();

      // Drop start, let the stream run out, then flag anything still owed.
      start <= 1'b0;
      waited = 0;
      while (pending_pixels.size() != 0 && waited < 200) begin
         @(posedge clock);
         waited++;
      end
      if (pending_pixels.size() != 0) begin
         $display("%0t: %0d words never arrived, expected x=%0d y=%0d actual none",
                  $time, pending_pixels.size(), pending_pixels[0].px,
                  pending_pixels[0].py);
         mismatches++;
      end
      repeat (10) @(posedge clock);
      if (mismatches == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
